// ----- rtl/threshold_centroid_macros.svh -----
// ----------------------------------------------------------------------------
// threshold centroid assertion macros
// shared concurrent assertion forms, clocked on clk_i, off during reset
// ----------------------------------------------------------------------------
`ifndef THRESHOLD_CENTROID_MACROS_SVH
`define THRESHOLD_CENTROID_MACROS_SVH

// same-cycle implication
`define TC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/tc_pkg.sv -----
// ----------------------------------------------------------------------------
// tc_pkg
// widths, reset values, codes and shared types of the threshold centroid block
// ----------------------------------------------------------------------------
package tc_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;

  localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  localparam int PIX_W      = 8;
  localparam int THR_W      = 8;
  localparam int IW_W       = 12;
  localparam int WW         = IW_W + 2;
  localparam int CFG_DATA_W = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int SUM_W      = 33;
  localparam int CNT_W      = 23;
  localparam int CENT_W     = 19;
  localparam int FRAC_W     = 8;
  localparam int OVF_SH     = CENT_W - FRAC_W;
  localparam int REM_W      = CNT_W;
  localparam int STEP_W     = $clog2(CENT_W);

  localparam logic [THR_W-1:0] THRESH_RESET = 8'h82;
  localparam logic [IW_W-1:0]  WIDTH_RESET  = 12'd1200;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH = 2'd1;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CENT_W - 1);

  typedef enum logic [3:0] {
    S_RUN  = 4'b0001,
    S_PREP = 4'b0010,
    S_DIV  = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  typedef struct packed {
    logic accept;
    logic last;
    logic prep;
    logic step;
    logic load_out;
  } cmd_t;

endpackage

// ----- rtl/tc_ctrl.sv -----
// ----------------------------------------------------------------------------
// tc_ctrl
// sequencer: pixel accumulation, divider setup, division steps, result handoff
// ----------------------------------------------------------------------------
`include "threshold_centroid_macros.svh"

module tc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          frame_end_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output tc_pkg::cmd_t  cmd_o
);

  tc_pkg::state_e                state_q, state_d;
  logic [tc_pkg::STEP_W-1:0]     step_q, step_d;
  logic                          out_valid_q, out_valid_d;
  logic                          slot_free;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == tc_pkg::S_RUN);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d        = state_q;
    step_d         = step_q;
    cmd_o          = '0;
    cmd_o.accept   = in_ready_o && in_valid_i;
    cmd_o.last     = in_ready_o && in_valid_i && frame_end_i;
    case (state_q)
      tc_pkg::S_RUN: begin
        if (cmd_o.last) state_d = tc_pkg::S_PREP;
      end
      tc_pkg::S_PREP: begin
        cmd_o.prep = 1'b1;
        step_d     = '0;
        state_d    = tc_pkg::S_DIV;
      end
      tc_pkg::S_DIV: begin
        cmd_o.step = 1'b1;
        step_d     = step_q + 1'b1;
        if (step_q == tc_pkg::LAST_STEP) state_d = tc_pkg::S_DONE;
      end
      tc_pkg::S_DONE: begin
        if (slot_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = tc_pkg::S_RUN;
        end
      end
      default: state_d = tc_pkg::S_RUN;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.load_out) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tc_pkg::S_RUN;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  `TC_ASSERT_NEXT(a_last_stalls, cmd_o.last, !in_ready_o, "input not stalled after frame end")
  `TC_ASSERT_IMPL(a_load_free, cmd_o.load_out, slot_free, "result loaded over pending result")
  `TC_ASSERT_IMPL(a_step_range, state_q == tc_pkg::S_DIV, step_q <= tc_pkg::LAST_STEP,
                  "division step count out of range")

endmodule

// ----- rtl/tc_datapath.sv -----
// ----------------------------------------------------------------------------
// tc_datapath
// config registers, position counters, saturating sums, restoring divider
// ----------------------------------------------------------------------------
module tc_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic [tc_pkg::PIX_W-1:0]      pixel_i,
  input  tc_pkg::cmd_t                  cmd_i,
  output logic [tc_pkg::CENT_W-1:0]     centroid_x_o,
  output logic [tc_pkg::CENT_W-1:0]     centroid_y_o,
  output logic [tc_pkg::CNT_W-1:0]      dark_count_o,
  output logic                          no_pixels_o
);

  logic [tc_pkg::THR_W-1:0]  threshold_q;
  logic [tc_pkg::IW_W-1:0]   image_width_q;

  logic [tc_pkg::COL_W-1:0]  column_q, column_d;
  logic [tc_pkg::ROW_W-1:0]  row_q, row_d;
  logic [tc_pkg::SUM_W-1:0]  sum_x_q, sum_x_d, sum_y_q, sum_y_d;
  logic [tc_pkg::CNT_W-1:0]  hits_q, hits_d;

  logic [tc_pkg::WW-1:0]     width_wide;
  logic [tc_pkg::COL_W:0]    width_eff;
  logic [tc_pkg::COL_W-1:0]  col_eff;
  logic [tc_pkg::COL_W:0]    col_inc;
  logic                      hit;
  logic [tc_pkg::SUM_W:0]    sx_wide, sy_wide;
  logic [tc_pkg::SUM_W-1:0]  sx_sat, sy_sat;
  logic [tc_pkg::CNT_W-1:0]  hits_sat;

  logic [tc_pkg::SUM_W-1:0]  dvd_x_q, dvd_y_q;
  logic [tc_pkg::CNT_W-1:0]  cnt_q;
  logic [tc_pkg::REM_W-1:0]  rem_x_q, rem_y_q;
  logic [tc_pkg::CENT_W-1:0] lo_x_q, lo_y_q;
  logic                      ovf_x_q, ovf_y_q, zero_q;
  logic [tc_pkg::REM_W:0]    t_x, t_y, dsr;
  logic                      ge_x, ge_y;

  logic [tc_pkg::CENT_W-1:0] cx_q, cy_q;
  logic [tc_pkg::CNT_W-1:0]  dark_q;
  logic                      nopix_q;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q   <= tc_pkg::THRESH_RESET;
      image_width_q <= tc_pkg::WIDTH_RESET;
    end else if (cfg_we_i) begin
      if (cfg_index_i == tc_pkg::CFG_THRESHOLD) begin
        threshold_q <= cfg_data_i[tc_pkg::THR_W-1:0];
      end else if (cfg_index_i == tc_pkg::CFG_IMAGE_WIDTH) begin
        image_width_q <= cfg_data_i[tc_pkg::IW_W-1:0];
      end
    end
  end

  // effective width and column
  always_comb begin
    width_wide = tc_pkg::WW'(image_width_q);
    if (width_wide == '0) begin
      width_wide = tc_pkg::WW'(1);
    end else if (width_wide > tc_pkg::WW'(tc_pkg::MAX_WIDTH)) begin
      width_wide = tc_pkg::WW'(tc_pkg::MAX_WIDTH);
    end
    width_eff = width_wide[tc_pkg::COL_W:0];
    if ({1'b0, column_q} >= width_eff) begin
      col_eff = tc_pkg::COL_W'(width_eff - 1'b1);
    end else begin
      col_eff = column_q;
    end
    col_inc = {1'b0, col_eff} + 1'b1;
  end

  assign hit      = pixel_i < threshold_q;
  assign sx_wide  = {1'b0, sum_x_q} + (tc_pkg::SUM_W + 1)'(col_eff);
  assign sy_wide  = {1'b0, sum_y_q} + (tc_pkg::SUM_W + 1)'(row_q);
  assign sx_sat   = sx_wide[tc_pkg::SUM_W] ? '1 : sx_wide[tc_pkg::SUM_W-1:0];
  assign sy_sat   = sy_wide[tc_pkg::SUM_W] ? '1 : sy_wide[tc_pkg::SUM_W-1:0];
  assign hits_sat = (&hits_q) ? hits_q : hits_q + 1'b1;

  always_comb begin
    sum_x_d  = hit ? sx_sat : sum_x_q;
    sum_y_d  = hit ? sy_sat : sum_y_q;
    hits_d   = hit ? hits_sat : hits_q;
    column_d = tc_pkg::COL_W'(col_inc);
    row_d    = row_q;
    if (col_inc >= width_eff) begin
      column_d = '0;
      if (row_q != tc_pkg::ROW_W'(tc_pkg::MAX_HEIGHT - 1)) row_d = row_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q <= '0;
      row_q    <= '0;
      sum_x_q  <= '0;
      sum_y_q  <= '0;
      hits_q   <= '0;
    end else if (cmd_i.accept) begin
      if (cmd_i.last) begin
        column_q <= '0;
        row_q    <= '0;
        sum_x_q  <= '0;
        sum_y_q  <= '0;
        hits_q   <= '0;
      end else begin
        column_q <= column_d;
        row_q    <= row_d;
        sum_x_q  <= sum_x_d;
        sum_y_q  <= sum_y_d;
        hits_q   <= hits_d;
      end
    end
  end

  // divider
  assign dsr  = {1'b0, cnt_q};
  assign t_x  = {rem_x_q, lo_x_q[tc_pkg::CENT_W-1]};
  assign t_y  = {rem_y_q, lo_y_q[tc_pkg::CENT_W-1]};
  assign ge_x = t_x >= dsr;
  assign ge_y = t_y >= dsr;

  always_ff @(posedge clk_i) begin
    if (cmd_i.last) begin
      dvd_x_q <= sum_x_d;
      dvd_y_q <= sum_y_d;
      cnt_q   <= hits_d;
    end
    if (cmd_i.prep) begin
      zero_q  <= (cnt_q == '0);
      ovf_x_q <= {1'b0, dvd_x_q} >= (tc_pkg::SUM_W + 1)'({cnt_q, tc_pkg::OVF_SH'(0)});
      ovf_y_q <= {1'b0, dvd_y_q} >= (tc_pkg::SUM_W + 1)'({cnt_q, tc_pkg::OVF_SH'(0)});
      rem_x_q <= tc_pkg::REM_W'(dvd_x_q >> tc_pkg::OVF_SH);
      rem_y_q <= tc_pkg::REM_W'(dvd_y_q >> tc_pkg::OVF_SH);
      lo_x_q  <= {dvd_x_q[tc_pkg::OVF_SH-1:0], tc_pkg::FRAC_W'(0)};
      lo_y_q  <= {dvd_y_q[tc_pkg::OVF_SH-1:0], tc_pkg::FRAC_W'(0)};
    end
    if (cmd_i.step) begin
      rem_x_q <= ge_x ? tc_pkg::REM_W'(t_x - dsr) : tc_pkg::REM_W'(t_x);
      rem_y_q <= ge_y ? tc_pkg::REM_W'(t_y - dsr) : tc_pkg::REM_W'(t_y);
      lo_x_q  <= {lo_x_q[tc_pkg::CENT_W-2:0], ge_x};
      lo_y_q  <= {lo_y_q[tc_pkg::CENT_W-2:0], ge_y};
    end
    if (cmd_i.load_out) begin
      cx_q    <= zero_q ? '0 : (ovf_x_q ? '1 : lo_x_q);
      cy_q    <= zero_q ? '0 : (ovf_y_q ? '1 : lo_y_q);
      dark_q  <= cnt_q;
      nopix_q <= zero_q;
    end
  end

  assign centroid_x_o = cx_q;
  assign centroid_y_o = cy_q;
  assign dark_count_o = dark_q;
  assign no_pixels_o  = nopix_q;

endmodule

// ----- rtl/threshold_centroid.sv -----
// ----------------------------------------------------------------------------
// threshold_centroid
// centroid and count of the pixels below a gray threshold, one result a frame
// ----------------------------------------------------------------------------
// Pixels of a frame are taken one per cycle in raster order; each pixel
// below the threshold adds its column and row to saturating sums. The
// item that carries frame_end closes the frame: input then stalls through a
// setup state, the steps of a one-bit-per-cycle restoring divider working
// on both axes at once and the load of the result register, and longer
// while an earlier result is still untaken. Centroids carry 8 fraction
// bits, truncated; an empty frame gives no_pixels with zero centroids.
// ----------------------------------------------------------------------------
module threshold_centroid (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [tc_pkg::PIX_W-1:0]      pixel_i,
  input  logic                          frame_end_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [tc_pkg::CENT_W-1:0]     centroid_x_o,
  output logic [tc_pkg::CENT_W-1:0]     centroid_y_o,
  output logic [tc_pkg::CNT_W-1:0]      dark_count_o,
  output logic                          no_pixels_o
);

  tc_pkg::cmd_t cmd;

  tc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .frame_end_i (frame_end_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  tc_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .pixel_i      (pixel_i),
    .cmd_i        (cmd),
    .centroid_x_o (centroid_x_o),
    .centroid_y_o (centroid_y_o),
    .dark_count_o (dark_count_o),
    .no_pixels_o  (no_pixels_o)
  );

endmodule

// ----- tb/centroid_checker.sv -----
// ----------------------------------------------------------------------------
// centroid_checker
// predicts the per-frame centroid results and compares them with the block
// ----------------------------------------------------------------------------
// Follows register writes and accepted pixels. It keeps its own column, row,
// saturating sums and dark count, and queues one expected result on every
// frame_end item. Each accepted result is compared field by field with the
// oldest queued one. The failure count and the number of results still due
// go back to the testbench top.
// ----------------------------------------------------------------------------
module centroid_checker
  import tc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [PIX_W-1:0]      pixel_i,
  input  logic                  frame_end_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic [CENT_W-1:0]     centroid_x_i,
  input  logic [CENT_W-1:0]     centroid_y_i,
  input  logic [CNT_W-1:0]      dark_count_i,
  input  logic                  no_pixels_i,
  output int                    pending_o,
  output int                    fails_o,
  output int                    results_o
);

  typedef struct packed {
    logic [CENT_W-1:0] cx;
    logic [CENT_W-1:0] cy;
    logic [CNT_W-1:0]  count;
    logic              no_pix;
  } centroid_t;

  localparam longint unsigned SUM_CAP  = (64'd1 << SUM_W) - 64'd1;
  localparam longint unsigned CNT_CAP  = (64'd1 << CNT_W) - 64'd1;
  localparam longint unsigned CENT_CAP = (64'd1 << CENT_W) - 64'd1;

  centroid_t        centroid_due_q[$];
  logic [THR_W-1:0] thr_q;
  logic [IW_W-1:0]  width_q;
  int unsigned      col_q;
  int unsigned      row_q;
  longint unsigned  sumx_q;
  longint unsigned  sumy_q;
  longint unsigned  hits_q;

  function automatic longint unsigned capped_add(input longint unsigned a,
                                                 input longint unsigned b,
                                                 input longint unsigned cap);
    longint unsigned s;
    s = a + b;
    return (s > cap) ? cap : s;
  endfunction

  function automatic longint unsigned scaled_mean(input longint unsigned total,
                                                  input longint unsigned n);
    longint unsigned q;
    if (n == 0) return 0;
    q = (total << FRAC_W) / n;
    return (q > CENT_CAP) ? CENT_CAP : q;
  endfunction

  task automatic clear_frame();
    col_q  = 0;
    row_q  = 0;
    sumx_q = 0;
    sumy_q = 0;
    hits_q = 0;
  endtask

  task automatic accumulate_pixel(input logic [PIX_W-1:0] pix, input logic last);
    int unsigned span;
    centroid_t   res;
    span = width_q;
    if (span == 0) span = 1;
    if (span > MAX_WIDTH) span = MAX_WIDTH;
    if (col_q >= span) col_q = span - 1;
    if (pix < thr_q) begin
      sumx_q = capped_add(sumx_q, col_q, SUM_CAP);
      sumy_q = capped_add(sumy_q, row_q, SUM_CAP);
      hits_q = capped_add(hits_q, 1, CNT_CAP);
    end
    if (last) begin
      res.cx     = CENT_W'(scaled_mean(sumx_q, hits_q));
      res.cy     = CENT_W'(scaled_mean(sumy_q, hits_q));
      res.count  = CNT_W'(hits_q);
      res.no_pix = (hits_q == 0);
      centroid_due_q.push_back(res);
      clear_frame();
    end else if (col_q + 1 >= span) begin
      col_q = 0;
      if (row_q + 1 < MAX_HEIGHT) row_q = row_q + 1;
    end else begin
      col_q = col_q + 1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    centroid_t want;
    if (!rst_ni) begin
      thr_q   = THRESH_RESET;
      width_q = WIDTH_RESET;
      clear_frame();
      centroid_due_q.delete();
      pending_o = 0;
      fails_o   = 0;
      results_o = 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        accumulate_pixel(pixel_i, frame_end_i);
      end
      // a write lands after the pixel of the same edge
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_THRESHOLD: begin
            thr_q = cfg_data_i[THR_W-1:0];
          end
          CFG_IMAGE_WIDTH: begin
            width_q = cfg_data_i[IW_W-1:0];
          end
          default: begin
          end
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        results_o++;
        if (centroid_due_q.size() == 0) begin
          $error("result item with no frame pending");
          fails_o++;
        end else begin
          want = centroid_due_q.pop_front();
          if (centroid_x_i !== want.cx) begin
            $error("centroid_x: expected %0d, got %0d", want.cx, centroid_x_i);
            fails_o++;
          end
          if (centroid_y_i !== want.cy) begin
            $error("centroid_y: expected %0d, got %0d", want.cy, centroid_y_i);
            fails_o++;
          end
          if (dark_count_i !== want.count) begin
            $error("dark_count: expected %0d, got %0d", want.count, dark_count_i);
            fails_o++;
          end
          if (no_pixels_i !== want.no_pix) begin
            $error("no_pixels: expected %0d, got %0d", want.no_pix, no_pixels_i);
            fails_o++;
          end
        end
      end
      pending_o = centroid_due_q.size();
    end
  end

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// stimulus and verdict for the threshold centroid block
// ----------------------------------------------------------------------------
// Drives frames of pixels through the block under several threshold and
// width settings: a directed part for the edge cases (empty frames, one-pixel
// frames, threshold extremes, width zero, unused register indexes), then
// random frames with random gaps on both sides, under widths that include
// zero and values above the maximum. The checker beside the block predicts
// and compares results.
// ----------------------------------------------------------------------------
module tb_top;
  import tc_pkg::*;

  localparam int PIXEL_TARGET  = 1800;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 300;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [PIX_W-1:0]      pixel = '0;
  logic                  frame_end = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [CENT_W-1:0]     centroid_x;
  logic [CENT_W-1:0]     centroid_y;
  logic [CNT_W-1:0]      dark_count;
  logic                  no_pixels;

  int                    pending;
  int                    fails;
  int                    results;

  logic [THR_W-1:0]      thr_now = THRESH_RESET;
  bit                    tx_calm = 1'b0;
  int                    hold_reqs = 0;
  int                    pixels_sent = 0;
  int                    frames_sent = 0;
  int                    reg_writes = 0;

  threshold_centroid dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .pixel_i      (pixel),
    .frame_end_i  (frame_end),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .centroid_x_o (centroid_x),
    .centroid_y_o (centroid_y),
    .dark_count_o (dark_count),
    .no_pixels_o  (no_pixels)
  );

  centroid_checker u_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .pixel_i      (pixel),
    .frame_end_i  (frame_end),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .centroid_x_i (centroid_x),
    .centroid_y_i (centroid_y),
    .dark_count_i (dark_count),
    .no_pixels_i  (no_pixels),
    .pending_o    (pending),
    .fails_o      (fails),
    .results_o    (results)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #12_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [PIX_W-1:0] draw_pixel(input int dark_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return '0;
    if (r < 8) return '1;
    if (r < 12) return thr_now;
    if (r < 16 && thr_now != 0) return thr_now - 8'd1;
    if (thr_now != 0 && $urandom_range(0, 99) < dark_pct) begin
      return PIX_W'($urandom_range(0, thr_now - 1));
    end
    return PIX_W'($urandom_range(thr_now, 255));
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic push_pixel(input logic [PIX_W-1:0] pix, input logic last);
    int gap;
    gap = tx_calm ? 0 : draw_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  = 1'b1;
    pixel     = pix;
    frame_end = last;
    do @(posedge clk); while (!in_ready);
    pixels_sent++;
    if (last) frames_sent++;
    @(negedge clk);
  endtask

  task automatic send_frame(input int len, input int dark_pct);
    for (int i = 0; i < len; i++) begin
      push_pixel(draw_pixel(dark_pct), i == len - 1);
    end
  endtask

  // wait for every result, then give the divider time to go quiet
  task automatic settle();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] word);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = word;
    if (idx == CFG_THRESHOLD) thr_now = word[THR_W-1:0];
    reg_writes++;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  initial begin : receiver
    int stall_left;
    int stretch_left;
    int holds_done;
    bit calm;
    stall_left   = 0;
    stretch_left = 0;
    holds_done   = 0;
    calm         = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_reqs != holds_done) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        holds_done++;
        out_ready = 1'b1;
      end else begin
        if (stretch_left == 0) begin
          calm         = ($urandom_range(0, 3) == 0);
          stretch_left = $urandom_range(20, 200);
        end
        stretch_left--;
        if (calm) begin
          out_ready = 1'b1;
        end else if (stall_left > 0) begin
          stall_left--;
          out_ready = 1'b0;
        end else begin
          out_ready  = 1'b1;
          stall_left = draw_gap();
        end
      end
    end
  end

  initial begin : stimulus
    int base;
    int phase;
    int nframes;
    int len;
    int r;
    logic [CFG_DATA_W-1:0] word;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // reset settings: mixed frame, one dark pixel, one bright pixel
    push_pixel(8'd0, 1'b0);
    push_pixel(8'd255, 1'b0);
    push_pixel(8'd129, 1'b0);
    push_pixel(8'd130, 1'b0);
    push_pixel(8'd128, 1'b1);
    push_pixel(8'd0, 1'b1);
    push_pixel(8'd255, 1'b1);
    settle();

    // threshold zero counts nothing, upper data bits are dropped
    write_reg(CFG_THRESHOLD, 12'hF00);
    push_pixel(8'd0, 1'b0);
    push_pixel(8'd0, 1'b1);
    settle();
    write_reg(CFG_THRESHOLD, 12'hFFF);
    push_pixel(8'd255, 1'b0);
    push_pixel(8'd254, 1'b1);
    settle();

    // width zero acts as one column
    write_reg(CFG_IMAGE_WIDTH, 12'd0);
    repeat (4) push_pixel(8'd7, 1'b0);
    push_pixel(8'd200, 1'b1);
    settle();

    // unused indexes leave both registers alone
    write_reg(CFG_IMAGE_WIDTH, 12'd3);
    write_reg(CFG_SPARE_A, 12'hFFF);
    write_reg(CFG_SPARE_B, 12'h001);
    for (int i = 0; i < 7; i++) push_pixel(8'(i * 30), i == 6);
    settle();

    base  = pixels_sent;
    phase = 0;
    while (pixels_sent - base < PIXEL_TARGET) begin
      settle();
      if ($urandom_range(0, 2) != 0) begin
        r = $urandom_range(0, 9);
        word = (r == 0) ? '0 :
               (r == 1) ? CFG_DATA_W'(255) :
               (r == 2) ? CFG_DATA_W'(1) : CFG_DATA_W'($urandom_range(0, 255));
        word = word | CFG_DATA_W'($urandom_range(0, 15) << 8);
        write_reg(CFG_THRESHOLD, word);
      end
      if ($urandom_range(0, 2) != 0) begin
        r = $urandom_range(0, 9);
        case (r)
          0:       word = '0;
          1:       word = CFG_DATA_W'(1);
          2:       word = CFG_DATA_W'(2);
          3:       word = CFG_DATA_W'(MAX_WIDTH);
          4:       word = CFG_DATA_W'(MAX_WIDTH + 1);
          5:       word = 12'hFFF;
          8:       word = CFG_DATA_W'($urandom_range(41, 4095));
          9:       word = CFG_DATA_W'($urandom_range(1, 12));
          default: word = CFG_DATA_W'($urandom_range(3, 40));
        endcase
        write_reg(CFG_IMAGE_WIDTH, word);
      end
      if ($urandom_range(0, 7) == 0) begin
        write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
                  CFG_DATA_W'($urandom_range(0, 4095)));
      end
      tx_calm = ($urandom_range(0, 3) == 0);

      if (phase == 3) begin
        // receiver holds off while small frames keep coming
        hold_reqs++;
        repeat (6) send_frame(2, 50);
      end else begin
        nframes = $urandom_range(1, 6);
        repeat (nframes) begin
          r = $urandom_range(0, 99);
          if (r < 80) len = $urandom_range(1, 24);
          else if (r < 97) len = $urandom_range(25, 120);
          else len = $urandom_range(121, 400);
          send_frame(len, $urandom_range(0, 100));
        end
      end
      phase++;
    end
    settle();

    $display("run covered %0d pixels in %0d frames, %0d results compared",
             pixels_sent, frames_sent, results);
    $display("%0d register writes: threshold and width extremes, unused indexes",
             reg_writes);
    if (fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/tc_pkg.sv
rtl/tc_ctrl.sv
rtl/tc_datapath.sv
rtl/threshold_centroid.sv
tb/centroid_checker.sv
tb/tb_top.sv
